// ===== hdl/vsvc_pkg.sv =====
// ============================================================================
// Voxel surface classifier package
// Shared constants, register and action codes, the stage control struct and the coordinate width function.
// ============================================================================
package vsvc_pkg;

    localparam int MAX_SIZE_X_DEF  = 256;
    localparam int MAX_SIZE_Y_DEF  = 256;
    localparam int MAX_SIZE_Z_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int THRESHOLD_BITS  = 16;
    localparam int SIZE_BITS       = 9;
    localparam int SIZE_RESET      = 256;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_SIZE_X    = 2'd1,
        REG_SIZE_Y    = 2'd2,
        REG_SIZE_Z    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_FLUSH  = 1'b1
    } action_t;

    // Emit and last-voxel flags, which neighbours of the emitted voxel lie inside
    // the volume, plus the bit of the plane above when it arrives with the current request.
    typedef struct packed {
        logic emit;
        logic chk_xm;
        logic chk_xp;
        logic chk_ym;
        logic chk_yp;
        logic chk_zm;
        logic chk_zp;
        logic up_bit;
        logic last;
    } nbr_ctl_t;

    // Coordinate width for an axis of up to n voxels.
    function automatic int idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== hdl/vsvc_in_if.sv =====
// ============================================================================
// Voxel request channel
// Valid/ready channel carrying one voxel sample or one flush tick.
// ============================================================================
interface vsvc_in_if #(
    parameter int SAMPLE_BITS = vsvc_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink   (input valid, input action, input sample, output ready);
endinterface

// ===== hdl/vsvc_out_if.sv =====
// ============================================================================
// Voxel result channel
// Valid/ready channel carrying one classified voxel.
// ============================================================================
interface vsvc_out_if;
    logic valid;
    logic ready;
    logic is_foreground;
    logic is_surface;
    logic last_voxel;

    modport source (output valid, output is_foreground, output is_surface,
                    output last_voxel, input ready);
    modport sink   (input valid, input is_foreground, input is_surface,
                    input last_voxel, output ready);
endinterface

// ===== hdl/volume_surface_voxel_classifier.sv =====
// ============================================================================
// Volume surface voxel classifier
// Streaming binarization and 6-neighbour boundary detection over a volume.
// ============================================================================
// Voxel samples arrive in x, y, z raster order and are binarized as foreground
// when the sample is strictly greater than the threshold register. The block
// emits each voxel one plane after it arrives, with its bit, a surface flag
// (set when any 6-neighbour inside the volume holds the other bit) and a flag
// on the final voxel of the volume. Samples in the first plane produce no
// result; once the whole volume is in, each flush request drains one voxel of
// the last plane. Samples sent after the volume is full, and flushes sent
// before it is full, are dropped without a result. Writing any size register
// abandons the volume in progress; sizes of zero act as one and sizes above
// the MAX_SIZE parameters are clipped to them. Throughput is one request per
// cycle while the sink takes results, with no stall of its own: each request
// does at most one write and at most six bit reads of the two-plane window,
// spread over three copies of the window with two read ports each. A request
// passes three registers (input register, window read, result register) in
// that order before its result is offered to the sink.
// The window needs no clearing after reset, so the block takes requests right
// away.
// ============================================================================
module volume_surface_voxel_classifier #(
    parameter int MAX_SIZE_X  = vsvc_pkg::MAX_SIZE_X_DEF,
    parameter int MAX_SIZE_Y  = vsvc_pkg::MAX_SIZE_Y_DEF,
    parameter int MAX_SIZE_Z  = vsvc_pkg::MAX_SIZE_Z_DEF,
    parameter int SAMPLE_BITS = vsvc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vsvc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [vsvc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    vsvc_in_if.sink                             voxels,
    vsvc_out_if.source                          results
);
    import vsvc_pkg::*;

    localparam int XW    = idx_bits(MAX_SIZE_X);
    localparam int YW    = idx_bits(MAX_SIZE_Y);
    localparam int ZW    = idx_bits(MAX_SIZE_Z);
    localparam int AW    = 1 + YW + XW;
    localparam int DEPTH = 2 ** AW;

    // Sizes are kept as the index of the last voxel along each axis.
    localparam logic [XW-1:0] X_LAST_MAX = XW'(MAX_SIZE_X - 1);
    localparam logic [YW-1:0] Y_LAST_MAX = YW'(MAX_SIZE_Y - 1);
    localparam logic [ZW-1:0] Z_LAST_MAX = ZW'(MAX_SIZE_Z - 1);
    localparam logic [XW-1:0] X_LAST_RST =
        XW'(((MAX_SIZE_X < SIZE_RESET) ? MAX_SIZE_X : SIZE_RESET) - 1);
    localparam logic [YW-1:0] Y_LAST_RST =
        YW'(((MAX_SIZE_Y < SIZE_RESET) ? MAX_SIZE_Y : SIZE_RESET) - 1);
    localparam logic [ZW-1:0] Z_LAST_RST =
        ZW'(((MAX_SIZE_Z < SIZE_RESET) ? MAX_SIZE_Z : SIZE_RESET) - 1);
    localparam logic [THRESHOLD_BITS-1:0] THR_RST =
        THRESHOLD_BITS'((SAMPLE_BITS <= THRESHOLD_BITS) ? (1 << (SAMPLE_BITS - 1)) : 0);

    logic [THRESHOLD_BITS-1:0] thr_reg;
    logic [XW-1:0]             x_last_reg, x_last_next;
    logic [YW-1:0]             y_last_reg, y_last_next;
    logic [ZW-1:0]             z_last_reg, z_last_next;
    logic [SIZE_BITS-1:0]      size_raw;
    logic                      clear;

    logic                      adv;
    logic                      wr_en;
    logic                      wr_bit;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_c, rd_zm, rd_xm, rd_xp, rd_ym, rd_yp;
    logic                      bit_c, bit_zm, bit_xm, bit_xp, bit_ym, bit_yp;
    nbr_ctl_t                  ctl;

    // Configuration: a size write also restarts the volume.
    assign size_raw = cfg_data[SIZE_BITS-1:0];
    assign clear    = cfg_we && (cfg_reg_t'(cfg_index) != REG_THRESHOLD);

    always_comb
    begin
        if (size_raw == '0)
        begin
            x_last_next = '0;
            y_last_next = '0;
            z_last_next = '0;
        end
        else
        begin
            x_last_next = (32'(size_raw) > MAX_SIZE_X) ? X_LAST_MAX
                                                       : XW'(size_raw - SIZE_BITS'(1));
            y_last_next = (32'(size_raw) > MAX_SIZE_Y) ? Y_LAST_MAX
                                                       : YW'(size_raw - SIZE_BITS'(1));
            z_last_next = (32'(size_raw) > MAX_SIZE_Z) ? Z_LAST_MAX
                                                       : ZW'(size_raw - SIZE_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THR_RST;
            x_last_reg <= X_LAST_RST;
            y_last_reg <= Y_LAST_RST;
            z_last_reg <= Z_LAST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD: thr_reg    <= cfg_data[THRESHOLD_BITS-1:0];
                REG_SIZE_X:    x_last_reg <= x_last_next;
                REG_SIZE_Y:    y_last_reg <= y_last_next;
                REG_SIZE_Z:    z_last_reg <= z_last_next;
                default:       thr_reg    <= thr_reg;
            endcase
        end
    end

    vsvc_scan #(
        .XW          (XW),
        .YW          (YW),
        .ZW          (ZW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .clear     (clear),
        .voxels    (voxels),
        .threshold (thr_reg),
        .x_last    (x_last_reg),
        .y_last    (y_last_reg),
        .z_last    (z_last_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_bit    (wr_bit),
        .rd_c      (rd_c),
        .rd_zm     (rd_zm),
        .rd_xm     (rd_xm),
        .rd_xp     (rd_xp),
        .rd_ym     (rd_ym),
        .rd_yp     (rd_yp),
        .ctl       (ctl)
    );

    // Three identical copies of the window. The plane below shares its slot
    // with the incoming sample at the same (x, y); the read-first RAM returns
    // the old bit before the new one lands.
    vsvc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_ram_cz (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_bit),
        .re      (adv),
        .raddr_a (rd_c),
        .raddr_b (rd_zm),
        .rdata_a (bit_c),
        .rdata_b (bit_zm)
    );

    vsvc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_ram_x (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_bit),
        .re      (adv),
        .raddr_a (rd_xm),
        .raddr_b (rd_xp),
        .rdata_a (bit_xm),
        .rdata_b (bit_xp)
    );

    vsvc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_ram_y (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_bit),
        .re      (adv),
        .raddr_a (rd_ym),
        .raddr_b (rd_yp),
        .rdata_a (bit_ym),
        .rdata_b (bit_yp)
    );

    vsvc_classify u_classify (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .bit_c   (bit_c),
        .bit_zm  (bit_zm),
        .bit_xm  (bit_xm),
        .bit_xp  (bit_xp),
        .bit_ym  (bit_ym),
        .bit_yp  (bit_yp),
        .adv     (adv),
        .results (results)
    );

    // A voxel emitted on a sample reads its lower neighbour from the very
    // entry the sample overwrites.
    a_zm_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && ctl.emit) |-> (rd_zm == wr_addr))
        else $error("lower-plane read does not match the overwritten entry");

    // The final voxel of a volume can only be drained by a flush.
    a_last_on_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit && ctl.last) |-> !wr_en)
        else $error("final voxel emitted on a sample request");

    // Requests are refused only while a result waits on a stalled sink.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !voxels.ready |-> (results.valid && !results.ready))
        else $error("request channel stalled without a stalled result");

    // Every emission reaches the result register.
    a_emit_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> ##2 results.valid)
        else $error("emitted voxel did not reach the result register");
endmodule

// ===== hdl/vsvc_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and two read ports, read data registered, read-first.
// ============================================================================
module vsvc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2 * vsvc_pkg::MAX_SIZE_X_DEF * vsvc_pkg::MAX_SIZE_Y_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;
endmodule

// ===== hdl/vsvc_scan.sv =====
// ============================================================================
// Voxel scan control
// Input register, raster position counters, binarization, window addresses.
// ============================================================================
module vsvc_scan #(
    parameter int XW          = vsvc_pkg::idx_bits(vsvc_pkg::MAX_SIZE_X_DEF),
    parameter int YW          = vsvc_pkg::idx_bits(vsvc_pkg::MAX_SIZE_Y_DEF),
    parameter int ZW          = vsvc_pkg::idx_bits(vsvc_pkg::MAX_SIZE_Z_DEF),
    parameter int SAMPLE_BITS = vsvc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                clear,
    vsvc_in_if.sink                             voxels,
    input  logic [vsvc_pkg::THRESHOLD_BITS-1:0] threshold,
    input  logic [XW-1:0]                       x_last,
    input  logic [YW-1:0]                       y_last,
    input  logic [ZW-1:0]                       z_last,
    output logic                                wr_en,
    output logic [XW+YW:0]                      wr_addr,
    output logic                                wr_bit,
    output logic [XW+YW:0]                      rd_c,
    output logic [XW+YW:0]                      rd_zm,
    output logic [XW+YW:0]                      rd_xm,
    output logic [XW+YW:0]                      rd_xp,
    output logic [XW+YW:0]                      rd_ym,
    output logic [XW+YW:0]                      rd_yp,
    output vsvc_pkg::nbr_ctl_t                  ctl
);
    import vsvc_pkg::*;

    localparam int CW = (SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS;

    logic                   s1_valid_reg;
    logic                   s1_action_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;

    logic [XW-1:0] ix_reg, ix_next, ox_reg, ox_next;
    logic [YW-1:0] iy_reg, iy_next, oy_reg, oy_next;
    logic [ZW-1:0] iz_reg, iz_next, oz_reg, oz_next;
    logic          in_done_reg, in_done_next;

    logic fire, is_sample, fg, emit_sample, emit_flush, emit;
    logic ix_end, iy_end, iz_end, ox_end, oy_end, oz_end, out_final;

    assign voxels.ready = adv || !s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (voxels.ready)
        begin
            s1_valid_reg <= voxels.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (voxels.ready && voxels.valid)
        begin
            s1_action_reg <= voxels.action;
            s1_sample_reg <= voxels.sample;
        end
    end

    assign fire        = s1_valid_reg && adv;
    assign is_sample   = (s1_action_reg == ACT_SAMPLE);
    assign fg          = CW'(s1_sample_reg) > CW'(threshold);
    assign wr_en       = fire && is_sample && !in_done_reg;
    assign emit_sample = wr_en && (iz_reg != '0);
    assign emit_flush  = fire && !is_sample && in_done_reg;
    assign emit        = emit_sample || emit_flush;

    assign ix_end    = (ix_reg == x_last);
    assign iy_end    = (iy_reg == y_last);
    assign iz_end    = (iz_reg == z_last);
    assign ox_end    = (ox_reg == x_last);
    assign oy_end    = (oy_reg == y_last);
    assign oz_end    = (oz_reg == z_last);
    assign out_final = ox_end && oy_end && oz_end;

    always_comb
    begin
        ix_next      = ix_reg;
        iy_next      = iy_reg;
        iz_next      = iz_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        oz_next      = oz_reg;
        in_done_next = in_done_reg;

        if (wr_en)
        begin
            if (!ix_end)
            begin
                ix_next = ix_reg + XW'(1);
            end
            else
            begin
                ix_next = '0;
                if (!iy_end)
                begin
                    iy_next = iy_reg + YW'(1);
                end
                else
                begin
                    iy_next = '0;
                    if (!iz_end)
                    begin
                        iz_next = iz_reg + ZW'(1);
                    end
                    else
                    begin
                        iz_next      = '0;
                        in_done_next = 1'b1;
                    end
                end
            end
        end

        if (emit)
        begin
            if (!ox_end)
            begin
                ox_next = ox_reg + XW'(1);
            end
            else
            begin
                ox_next = '0;
                if (!oy_end)
                begin
                    oy_next = oy_reg + YW'(1);
                end
                else
                begin
                    oy_next = '0;
                    if (!oz_end)
                    begin
                        oz_next = oz_reg + ZW'(1);
                    end
                    else
                    begin
                        // Final voxel drained: the next sample opens a new volume.
                        oz_next      = '0;
                        in_done_next = 1'b0;
                    end
                end
            end
        end

        if (clear)
        begin
            ix_next      = '0;
            iy_next      = '0;
            iz_next      = '0;
            ox_next      = '0;
            oy_next      = '0;
            oz_next      = '0;
            in_done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ix_reg      <= '0;
            iy_reg      <= '0;
            iz_reg      <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            oz_reg      <= '0;
            in_done_reg <= 1'b0;
        end
        else
        begin
            ix_reg      <= ix_next;
            iy_reg      <= iy_next;
            iz_reg      <= iz_next;
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            oz_reg      <= oz_next;
            in_done_reg <= in_done_next;
        end
    end

    // The window holds two plane slots selected by the low bit of z.
    assign wr_bit  = fg;
    assign wr_addr = {iz_reg[0], iy_reg, ix_reg};
    assign rd_c    = {oz_reg[0], oy_reg, ox_reg};
    assign rd_zm   = {~oz_reg[0], oy_reg, ox_reg};
    assign rd_xm   = {oz_reg[0], oy_reg, ox_reg - XW'(1)};
    assign rd_xp   = {oz_reg[0], oy_reg, ox_reg + XW'(1)};
    assign rd_ym   = {oz_reg[0], oy_reg - YW'(1), ox_reg};
    assign rd_yp   = {oz_reg[0], oy_reg + YW'(1), ox_reg};

    always_comb
    begin
        ctl.emit   = emit;
        ctl.chk_xm = (ox_reg != '0);
        ctl.chk_xp = !ox_end;
        ctl.chk_ym = (oy_reg != '0);
        ctl.chk_yp = !oy_end;
        ctl.chk_zm = (oz_reg != '0);
        ctl.chk_zp = emit_sample;
        ctl.up_bit = fg;
        ctl.last   = out_final;
    end
endmodule

// ===== hdl/vsvc_classify.sv =====
// ============================================================================
// Voxel neighbour compare
// Compares the window bits of the emitted voxel and holds the result register.
// ============================================================================
module vsvc_classify (
    input  logic               clk,
    input  logic               rst_n,
    input  vsvc_pkg::nbr_ctl_t ctl,
    input  logic               bit_c,
    input  logic               bit_zm,
    input  logic               bit_xm,
    input  logic               bit_xp,
    input  logic               bit_ym,
    input  logic               bit_yp,
    output logic               adv,
    vsvc_out_if.source         results
);
    import vsvc_pkg::*;

    nbr_ctl_t ctl_reg;
    logic     res_valid_reg;
    logic     fg_reg;
    logic     surf_reg;
    logic     last_reg;
    logic     surf;

    assign adv = !res_valid_reg || results.ready;

    always_comb
    begin
        surf = (ctl_reg.chk_xm && (bit_xm != bit_c))
            || (ctl_reg.chk_xp && (bit_xp != bit_c))
            || (ctl_reg.chk_ym && (bit_ym != bit_c))
            || (ctl_reg.chk_yp && (bit_yp != bit_c))
            || (ctl_reg.chk_zm && (bit_zm != bit_c))
            || (ctl_reg.chk_zp && (ctl_reg.up_bit != bit_c));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ctl_reg       <= ctl;
            res_valid_reg <= ctl_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fg_reg   <= bit_c;
            surf_reg <= surf;
            last_reg <= ctl_reg.last;
        end
    end

    assign results.valid         = res_valid_reg;
    assign results.is_foreground = fg_reg;
    assign results.is_surface    = surf_reg;
    assign results.last_voxel    = last_reg;
endmodule
